// ----- design/mhc_pkg.sv -----
// Shared types and constants for the median hysteresis classifier.
// No dependencies; imported by every module of the block.
`default_nettype none
package mhc_pkg;

    // Window depth and field widths
    localparam int WINDOW     = 5;
    localparam int SAMPLE_W   = 10;
    localparam int LIGHT_W    = 11;
    localparam int AGE_W      = $clog2(WINDOW);
    localparam int MID_CELL   = WINDOW / 2;
    localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT = 1'b0,
        REG_DARK  = 1'b1
    } t_cfg_reg;

    // Stream widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Link from a cell to the cell above it (after the oldest entry is removed)
    typedef struct packed {
        logic                shift;      // oldest entry sits at or below this cell
        logic [SAMPLE_W-1:0] value;      // surviving value at this place
        logic [AGE_W-1:0]    age;        // its age
        logic                gt;         // surviving value is above the new sample
    } t_up_link;

    // Link from a cell to the cell below it (its stored content)
    typedef struct packed {
        logic                present;
        logic [SAMPLE_W-1:0] value;
        logic [AGE_W-1:0]    age;
    } t_down_link;

endpackage
`default_nettype wire

// ----- design/mhc_cell.sv -----
// One cell of the sorted window: holds one value and its age.
// Depends on mhc_pkg; instantiated by mhc_chain.
`default_nettype none
module mhc_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic [mhc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [mhc_pkg::AGE_W-1:0]    i_reset_age,
    input  wire mhc_pkg::t_up_link            i_below,
    input  wire mhc_pkg::t_down_link          i_above,
    output mhc_pkg::t_up_link                 o_up,
    output mhc_pkg::t_down_link               o_down
);
    import mhc_pkg::*;

    logic [SAMPLE_W-1:0] r_value, n_value;
    logic [AGE_W-1:0]    r_age, n_age;
    logic                w_shift;
    logic [SAMPLE_W-1:0] w_keep_value;
    logic [AGE_W-1:0]    w_keep_age;
    logic                w_gt;

    // Drop the oldest entry: cells above it move down by one place
    always_comb begin
        w_shift      = i_below.shift | (r_age == AGE_OLDEST);
        w_keep_value = w_shift ? i_above.value : r_value;
        w_keep_age   = w_shift ? i_above.age   : r_age;
        if (w_shift && !i_above.present) begin
            w_gt = 1'b1;
        end else begin
            w_gt = w_keep_value > i_sample;
        end
    end

    // Insert the new sample: larger survivors move up by one place
    always_comb begin
        if (i_below.gt) begin
            n_value = i_below.value;
            n_age   = i_below.age + AGE_W'(1);
        end else if (w_gt) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = w_keep_value;
            n_age   = w_keep_age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_age   <= i_reset_age;
        end else if (i_load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_up   = '{shift: w_shift, value: w_keep_value, age: w_keep_age, gt: w_gt};
    assign o_down = '{present: 1'b1, value: r_value, age: r_age};

endmodule
`default_nettype wire

// ----- design/mhc_chain.sv -----
// Row of sorting cells that keeps the window in ascending order.
// Depends on mhc_pkg and mhc_cell; instantiated by the top level.
`default_nettype none
module mhc_chain (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire logic [mhc_pkg::SAMPLE_W-1:0] i_sample,
    output logic [mhc_pkg::SAMPLE_W-1:0]      o_median
);
    import mhc_pkg::*;

    t_up_link   w_up   [WINDOW+1];
    t_down_link w_down [WINDOW+1];
    logic [WINDOW-1:0] w_oldest;
    logic [WINDOW-1:0] w_order_ok;

    // Ends of the chain: nothing below the first cell, nothing above the last
    assign w_up[0]        = '{shift: 1'b0, value: '0, age: '0, gt: 1'b0};
    assign w_down[WINDOW] = '{present: 1'b0, value: '0, age: '0};

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        mhc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (i_load),
            .i_sample    (i_sample),
            .i_reset_age (AGE_W'(WINDOW - 1 - g)),
            .i_below     (w_up[g]),
            .i_above     (w_down[g+1]),
            .o_up        (w_up[g+1]),
            .o_down      (w_down[g])
        );
        assign w_oldest[g] = (w_down[g].age == AGE_OLDEST);
        if (g == WINDOW - 1) begin : g_top
            assign w_order_ok[g] = 1'b1;
        end else begin : g_mid
            assign w_order_ok[g] = w_down[g].value <= w_down[g+1].value;
        end
    end

    assign o_median = w_down[MID_CELL].value;

`ifndef SYNTH
    // Exactly one cell holds the oldest entry
    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_oldest))
        else $error("window must hold exactly one oldest entry");

    // Cells stay in ascending order
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_ok)
        else $error("window cells out of order");

    // Without a load the window holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load |=> $stable(o_median))
        else $error("median changed without a new sample");
`endif

endmodule
`default_nettype wire

// ----- design/median_hysteresis_classifier.sv -----
// Top level: running median over a window of samples with a hysteresis classifier.
// Depends on mhc_pkg and mhc_chain.
//
// Use: one instance per sensor channel. Samples arrive on the slave stream
// (s_axis, tdata bits [9:0] = sample). Each accepted request replaces the
// oldest entry of the window; the median of the window and the classified
// level leave on the master stream (m_axis, tdata [9:0] = median_value,
// [10] = level).
// Path: an accepted sample first updates the row of sorting cells; the middle
// stage then compares the median with the thresholds and registers the result.
// Throughput: one sample per cycle while m_axis_tready stays high; the rate is
// set by the output handshake alone.
// Reset (synchronous, active low): window cleared to zeros, level 0,
// light threshold 0, dark threshold 1023, no result pending.
// Stall: when the receiver holds m_axis_tready low, the result register holds and
// one further sample waits in the middle stage; then s_axis_tready drops. The user
// writes thresholds on the cfg port only while idle; the block doesn't enforce it.
`default_nettype none
module median_hysteresis_classifier (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream: [9:0] sample
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [mhc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // master stream: [9:0] median_value, [10] level
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [mhc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [mhc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mhc_pkg::LIGHT_W-1:0]     i_cfg_data
);
    import mhc_pkg::*;

    logic [LIGHT_W-1:0]  r_light;
    logic [SAMPLE_W-1:0] r_dark;
    logic                r_mid_valid;
    logic                r_out_valid;
    logic                r_level, n_level;
    logic [SAMPLE_W-1:0] r_out_median;
    logic                w_accept;
    logic                w_advance;
    logic [SAMPLE_W-1:0] w_median;

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '0;
            r_dark  <= SAMPLE_W'(1023);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LIGHT: r_light <= i_cfg_data;
                REG_DARK:  r_dark  <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: advance the middle stage when the output register frees up
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_mid_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    mhc_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .o_median (w_median)
    );

    // Classify with hysteresis; the light test wins when both hold
    always_comb begin
        n_level = r_level;
        if ({1'b0, w_median} < r_light) begin
            n_level = 1'b1;
        end else if (w_median > r_dark) begin
            n_level = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_mid_valid <= 1'b1;
            end else if (w_advance) begin
                r_mid_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= r_mid_valid;
                if (r_mid_valid) begin
                    r_level <= n_level;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_advance && r_mid_valid) begin
            r_out_median <= w_median;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - SAMPLE_W - 1){1'b0}}, r_level, r_out_median};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for median_hysteresis_classifier: directed table, then random threshold phases.
// Runs its own window-median and hysteresis predictor and checks every result in order.
// Depends on mhc_pkg and the design files only.
`timescale 1ns / 100ps
module tb;
    import mhc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 175;
    localparam int LONG_HOLD_AT   = 300;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                level;
    } t_result;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        t_cfg_reg            cfg_sel;
        int unsigned         value;
        bit                  typed;
        logic [SAMPLE_W-1:0] exp_median;
        logic                exp_level;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [9:0] sample, [15:10] zero
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [9:0] median_value, [10] level, [15:11] zero
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [LIGHT_W-1:0]      i_cfg_data = '0;

    // Predictor state
    logic [SAMPLE_W-1:0] ring_samples [WINDOW];
    int unsigned         ring_wr;
    logic                level_state;
    logic [LIGHT_W-1:0]  light_lim;
    logic [SAMPLE_W-1:0] dark_lim;

    t_result     pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles = 0;
    logic [SAMPLE_W-1:0] last_smp = '0;
    t_dir_row    dir_rows [30];

    median_hysteresis_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Sort a copy of the ring and take the middle rank
    function automatic logic [SAMPLE_W-1:0] window_median();
        logic [SAMPLE_W-1:0] srt [WINDOW];
        logic [SAMPLE_W-1:0] v;
        int j;
        srt = ring_samples;
        for (int i = 1; i < WINDOW; i++) begin
            v = srt[i];
            j = i - 1;
            while (j >= 0 && srt[j] > v) begin
                srt[j + 1] = srt[j];
                j--;
            end
            srt[j + 1] = v;
        end
        return srt[WINDOW / 2];
    endfunction

    // Insert a sample, take the median, apply the hysteresis (light test first)
    task automatic classify_sample(input logic [SAMPLE_W-1:0] smp, output t_result res);
        ring_samples[ring_wr] = smp;
        ring_wr = (ring_wr == WINDOW - 1) ? 0 : ring_wr + 1;
        res.median = window_median();
        if ({1'b0, res.median} < light_lim) begin
            level_state = 1'b1;
        end else if (res.median > dark_lim) begin
            level_state = 1'b0;
        end
        res.level = level_state;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Mostly random, with values hugging both thresholds, extremes and repeats
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 1023);
            4, 5:       v = int'(light_lim) + $urandom_range(0, 4) - 2;
            6:          v = int'(dark_lim) + $urandom_range(0, 4) - 2;
            7:          v = $urandom_range(0, 1) ? 1023 : 0;
            default:    v = int'(last_smp);
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SAMPLE_W'(v);
    endfunction

    // Offer one request and hold it until accepted, then idle for the gap
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input int unsigned gap,
                               input bit typed, input t_result typed_res);
        t_result res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(smp);
        do @(posedge i_clk); while (!s_axis_tready);
        classify_sample(smp, res);
        if (typed) res = typed_res;
        pending_results.push_back(res);
        last_smp = smp;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result is back and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg sel, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= LIGHT_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == REG_LIGHT) begin
            light_lim = LIGHT_W'(val);
        end else begin
            dark_lim = SAMPLE_W'(val);
        end
        @(posedge i_clk);
    endtask

    task automatic check_result();
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, median",
                            m_axis_tdata[SAMPLE_W-1:0], -1);
        end else begin
            want = pending_results.pop_front();
            if (m_axis_tdata[SAMPLE_W-1:0] !== want.median)
                report_mismatch("median_value", m_axis_tdata[SAMPLE_W-1:0], want.median);
            if (m_axis_tdata[SAMPLE_W] !== want.level)
                report_mismatch("level", m_axis_tdata[SAMPLE_W], want.level);
        end
    endtask

    // Receiver: check each accepted result, then pick the next ready
    initial begin
        int unsigned hold_left;
        bit          long_done;
        int unsigned r;
        hold_left = 0;
        long_done = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) check_result();
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_done && results_seen >= LONG_HOLD_AT) begin
                // Long hold-off so the block fills and stalls its input
                long_done = 1;
                hold_left = 99;
                m_axis_tready <= 1'b0;
            end else if ((results_seen / 64) % 3 == 0) begin
                m_axis_tready <= 1'b1;
            end else if (r < 3) begin
                hold_left = $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (r < 75);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_result     typed_res;
        int unsigned light_set [8];
        int unsigned dark_set [8];
        int unsigned gap;

        for (int i = 0; i < WINDOW; i++) ring_samples[i] = '0;
        ring_wr     = 0;
        level_state = 1'b0;
        light_lim   = '0;
        dark_lim    = SAMPLE_W'(1023);

        // The first nine sample rows carry typed results; the rest go through the predictor
        dir_rows = '{
            '{ROW_SAMPLE, REG_LIGHT, 1023, 1, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 1023, 1, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 1023, 1, 1023, 0},
            '{ROW_SAMPLE, REG_LIGHT, 0,    1, 1023, 0},
            '{ROW_SAMPLE, REG_LIGHT, 0,    1, 1023, 0},
            '{ROW_SAMPLE, REG_LIGHT, 0,    1, 0,    0},
            // light at its widest: every median is light
            '{ROW_CFG,    REG_LIGHT, 2047, 0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 1023, 1, 0,    1},
            '{ROW_CFG,    REG_LIGHT, 0,    0, 0,    0},
            '{ROW_CFG,    REG_DARK,  0,    0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 512,  1, 0,    1},
            '{ROW_SAMPLE, REG_LIGHT, 1023, 1, 512,  0},
            // overlapping thresholds: light wins
            '{ROW_CFG,    REG_LIGHT, 600,  0, 0,    0},
            '{ROW_CFG,    REG_DARK,  400,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 500,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 1023, 0, 0,    0},
            // single-limit detector around 512
            '{ROW_CFG,    REG_LIGHT, 513,  0, 0,    0},
            '{ROW_CFG,    REG_DARK,  512,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 512,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 512,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 513,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 513,  0, 0,    0},
            // oversized dark value is cut to ten bits
            '{ROW_CFG,    REG_LIGHT, 1024, 0, 0,    0},
            '{ROW_CFG,    REG_DARK,  2047, 0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 1023, 0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 341,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 682,  0, 0,    0},
            '{ROW_CFG,    REG_LIGHT, 300,  0, 0,    0},
            '{ROW_CFG,    REG_DARK,  700,  0, 0,    0},
            '{ROW_SAMPLE, REG_LIGHT, 0,    0, 0,    0}
        };

        light_set = '{0,    2047, 1024, 0, 513, 300, 600, 0};
        dark_set  = '{1023, 0,    1023, 0, 512, 700, 400, 0};
        light_set[7] = $urandom_range(0, 2047);
        dark_set[7]  = $urandom_range(0, 1023);

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                drain();
                cfg_write(dir_rows[k].cfg_sel, dir_rows[k].value);
            end else begin
                typed_res.median = dir_rows[k].exp_median;
                typed_res.level  = dir_rows[k].exp_level;
                send_sample(SAMPLE_W'(dir_rows[k].value), pick_gap(),
                            dir_rows[k].typed, typed_res);
            end
        end

        // Random phases, one threshold pair each
        for (int p = 0; p < 8; p++) begin
            drain();
            cfg_write(REG_LIGHT, light_set[p]);
            cfg_write(REG_DARK, dark_set[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gap = (p % 3 == 1) ? 0 : pick_gap();
                send_sample(pick_sample(), gap, 0, typed_res);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
